// ===== src/ctsc_pkg.sv =====
`default_nettype none

package ctsc_pkg;

    // Stream widths
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 24;

    // Time constants
    localparam logic [4:0] LAST_HOUR   = 5'd23;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [5:0] HOURS_DAY   = 6'd24;
    localparam logic [6:0] MINS_HOUR   = 7'd60;

    // LED patterns
    localparam logic [7:0] LED_SHOW      = 8'd128;
    localparam logic [7:0] LED_EDIT_EVEN = 8'd16;
    localparam logic [7:0] LED_EDIT_ODD  = 8'd32;

    // Key operations
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_SHOW      = 3'd1,
        OP_TOGGLE    = 3'd2,
        OP_LOAD      = 3'd3,
        OP_HOUR_UP   = 3'd4,
        OP_MINUTE_UP = 3'd5
    } op_t;

    // Display mode
    typedef enum logic [1:0] {
        MODE_SHOW = 2'b01,
        MODE_EDIT = 2'b10
    } mode_t;

    // Four display digits
    typedef struct packed {
        logic [3:0] minute_ones;
        logic [2:0] minute_tens;
        logic [3:0] hour_ones;
        logic [1:0] hour_tens;
    } disp_t;

endpackage

`default_nettype wire

// ===== src/ctsc_digits.sv =====
`default_nettype none

module ctsc_digits (
    input  wire logic [4:0]     hour,
    input  wire logic [5:0]     minute,
    output ctsc_pkg::disp_t     disp
);
    import ctsc_pkg::*;

    // Split a value below 60 into tens and ones
    function automatic logic [6:0] dec_split(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] ones;
        begin
            priority if (v >= 6'd50) begin
                tens = 3'd5;
                ones = v - 6'd50;
            end else if (v >= 6'd40) begin
                tens = 3'd4;
                ones = v - 6'd40;
            end else if (v >= 6'd30) begin
                tens = 3'd3;
                ones = v - 6'd30;
            end else if (v >= 6'd20) begin
                tens = 3'd2;
                ones = v - 6'd20;
            end else if (v >= 6'd10) begin
                tens = 3'd1;
                ones = v - 6'd10;
            end else begin
                tens = 3'd0;
                ones = v;
            end
            dec_split = {tens, ones[3:0]};
        end
    endfunction

    logic [6:0] hour_split;
    logic [6:0] minute_split;

    assign hour_split   = dec_split({1'b0, hour});
    assign minute_split = dec_split(minute);

    // Hour tens never exceeds 2
    assign disp.hour_tens   = hour_split[5:4];
    assign disp.hour_ones   = hour_split[3:0];
    assign disp.minute_tens = minute_split[6:4];
    assign disp.minute_ones = minute_split[3:0];

endmodule

`default_nettype wire

// ===== src/clock_time_set_controller.sv =====
`default_nettype none

// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+----------------------------------------
// s_       | in  | s_tvalid/s_tready  | s_tdata: operation, board h/m/s
// m_       | out | m_tvalid/m_tready  | m_tdata: four digits, LED byte
//
// One result per request; new requests are taken every cycle unless m_ stalls.
// The input register comes first, then the result register, with the key
// update and digit split in between. Mode and time state update as a
// request moves into the result register. Reset clears mode, offset and
// edit time to show mode at zero. A stall on m_ holds the result and backs
// up through the input register to s_tready.

module clock_time_set_controller (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // [2:0] operation, [7:3] board_hour, [13:8] board_minute,
    // [19:14] board_second, [23:20] zero
    input  wire logic [ctsc_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] hour_tens, [5:2] hour_ones, [8:6] minute_tens,
    // [12:9] minute_ones, [20:13] led_pattern, [23:21] zero
    output logic [ctsc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);
    import ctsc_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [4:0] bh_reg;
    logic [5:0] bm_reg;
    logic       bs_odd_reg;

    // Time state; offset kept as hour and minute parts of one minute count
    mode_t      mode_reg,  mode_next;
    logic [4:0] off_hour_reg, off_hour_next;
    logic [5:0] off_min_reg,  off_min_next;
    logic [4:0] edit_hour_reg, edit_hour_next;
    logic [5:0] edit_min_reg,  edit_min_next;

    // Result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic       advance;
    logic       step;
    logic [4:0] bh_in;
    logic [5:0] bm_in;
    logic [4:0] bh_norm;
    logic [5:0] bm_norm;

    logic [6:0] min_sum;
    logic       min_carry;
    logic [5:0] shown_min;
    logic [5:0] hour_sum;
    logic [4:0] shown_hour;

    logic       borrow;
    logic [6:0] min_diff;
    logic [5:0] hour_diff;
    logic [5:0] save_min;
    logic [4:0] save_hour;

    logic [4:0] hour_inc;
    logic       saving;
    logic [4:0] disp_hour;
    logic [5:0] disp_min;
    logic [7:0] led;
    disp_t      disp;

    // Handshake
    assign advance  = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Board time brought into range on the way in
    assign bh_in   = s_tdata[7:3];
    assign bm_in   = s_tdata[13:8];
    assign bh_norm = ({1'b0, bh_in} >= HOURS_DAY) ? 5'(bh_in - 5'd24) : bh_in;
    assign bm_norm = ({1'b0, bm_in} >= MINS_HOUR) ? 6'(bm_in - 6'd60) : bm_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tdata[2:0];
            bh_reg     <= bh_norm;
            bm_reg     <= bm_norm;
            bs_odd_reg <= s_tdata[14];
        end
    end

    // Shown time: board plus offset
    assign min_sum    = {1'b0, bm_reg} + {1'b0, off_min_reg};
    assign min_carry  = (min_sum >= MINS_HOUR);
    assign shown_min  = min_carry ? 6'(min_sum - MINS_HOUR) : min_sum[5:0];
    assign hour_sum   = {1'b0, bh_reg} + {1'b0, off_hour_reg} + {5'b0, min_carry};
    assign shown_hour = (hour_sum >= HOURS_DAY) ? 5'(hour_sum - HOURS_DAY)
                                                : hour_sum[4:0];

    // New offset on save: edited time minus board time, mod one day
    assign borrow    = (edit_min_reg < bm_reg);
    assign min_diff  = {1'b0, edit_min_reg} + (borrow ? MINS_HOUR : 7'd0)
                       - {1'b0, bm_reg};
    assign save_min  = min_diff[5:0];
    assign hour_diff = {1'b0, edit_hour_reg} + HOURS_DAY - {1'b0, bh_reg}
                       - {5'b0, borrow};
    assign save_hour = (hour_diff >= HOURS_DAY) ? 5'(hour_diff - HOURS_DAY)
                                                : hour_diff[4:0];

    assign hour_inc = (edit_hour_reg == LAST_HOUR) ? 5'd0 : edit_hour_reg + 5'd1;

    // Key handling
    always_comb begin
        mode_next      = mode_reg;
        off_hour_next  = off_hour_reg;
        off_min_next   = off_min_reg;
        edit_hour_next = edit_hour_reg;
        edit_min_next  = edit_min_reg;
        saving         = 1'b0;
        unique case (op_reg)
            OP_SHOW: begin
                mode_next = MODE_SHOW;
            end
            OP_TOGGLE: begin
                if (mode_reg == MODE_SHOW) begin
                    mode_next      = MODE_EDIT;
                    edit_hour_next = shown_hour;
                    edit_min_next  = shown_min;
                end else begin
                    mode_next     = MODE_SHOW;
                    off_hour_next = save_hour;
                    off_min_next  = save_min;
                    saving        = 1'b1;
                end
            end
            OP_LOAD: begin
                if (mode_reg == MODE_EDIT) begin
                    edit_hour_next = bh_reg;
                    edit_min_next  = bm_reg;
                end
            end
            OP_HOUR_UP: begin
                if (mode_reg == MODE_EDIT) begin
                    edit_hour_next = hour_inc;
                end
            end
            OP_MINUTE_UP: begin
                if (mode_reg == MODE_EDIT) begin
                    if (edit_min_reg == LAST_MINUTE) begin
                        edit_min_next  = 6'd0;
                        edit_hour_next = hour_inc;
                    end else begin
                        edit_min_next = edit_min_reg + 6'd1;
                    end
                end
            end
            default: begin
                // no key, or an unused code
            end
        endcase
    end

    // Displayed time after the key; a save shows the edited time
    always_comb begin
        if (mode_next == MODE_EDIT) begin
            disp_hour = edit_hour_next;
            disp_min  = edit_min_next;
            led       = bs_odd_reg ? LED_EDIT_ODD : LED_EDIT_EVEN;
        end else if (saving) begin
            disp_hour = edit_hour_reg;
            disp_min  = edit_min_reg;
            led       = LED_SHOW;
        end else begin
            disp_hour = shown_hour;
            disp_min  = shown_min;
            led       = LED_SHOW;
        end
    end

    ctsc_digits u_digits (
        .hour   (disp_hour),
        .minute (disp_min),
        .disp   (disp)
    );

    assign m_data_next = {3'b000, led, disp};

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_SHOW;
            off_hour_reg  <= 5'd0;
            off_min_reg   <= 6'd0;
            edit_hour_reg <= 5'd0;
            edit_min_reg  <= 6'd0;
        end else if (step) begin
            mode_reg      <= mode_next;
            off_hour_reg  <= off_hour_next;
            off_min_reg   <= off_min_next;
            edit_hour_reg <= edit_hour_next;
            edit_min_reg  <= edit_min_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= m_data_next;
        end
    end

    // Checks
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (off_hour_reg <= LAST_HOUR) && (off_min_reg <= LAST_MINUTE)
        && (edit_hour_reg <= LAST_HOUR) && (edit_min_reg <= LAST_MINUTE))
        else $error("time state out of range");

    a_led_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg[20:13] == LED_SHOW)
            || (m_data_reg[20:13] == LED_EDIT_EVEN)
            || (m_data_reg[20:13] == LED_EDIT_ODD)))
        else $error("bad LED pattern");

    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg[5:2] <= 4'd9) && (m_data_reg[12:9] <= 4'd9)
            && (m_data_reg[8:6] <= 3'd5) && (m_data_reg[1:0] != 2'd3)
            && !((m_data_reg[1:0] == 2'd2) && (m_data_reg[5:2] > 4'd3))))
        else $error("display digits out of range");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(off_hour_reg) && $stable(off_min_reg)
            && $stable(edit_hour_reg) && $stable(edit_min_reg)))
        else $error("state changed without a request");

endmodule

`default_nettype wire
